// File: hw/rtl/vfv_pkg.sv
`timescale 1ns / 1ps

package vfv_pkg;

  localparam int AXIS_BITS  = 5;
  localparam int TYPE_BITS  = 4;
  localparam int SIZE_BITS  = 6;
  localparam int ADDR_BITS  = 3 * AXIS_BITS;
  localparam int CELL_COUNT = 1 << ADDR_BITS;
  localparam int FACE_COUNT = 6;
  localparam int IDX_BITS   = 2;
  localparam int CMP_BITS   = (AXIS_BITS + 1 > SIZE_BITS) ? AXIS_BITS + 1 : SIZE_BITS;
  localparam logic [CMP_BITS-1:0] AXIS_SIZE = CMP_BITS'(1 << AXIS_BITS);

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [IDX_BITS-1:0] REG_GRID_WIDE = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_GRID_HIGH = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_GRID_DEEP = 2'd2;

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(32);

  typedef struct packed {
    logic                 func;
    logic [AXIS_BITS-1:0] pos_x;
    logic [AXIS_BITS-1:0] pos_y;
    logic [AXIS_BITS-1:0] pos_z;
    logic [TYPE_BITS-1:0] new_type;
  } in_t;

  typedef struct packed {
    logic [TYPE_BITS-1:0]  cell_type;
    logic [FACE_COUNT-1:0] face_mask;
    logic                  out_of_range;
  } res_t;

  // Sizes beyond the memory act as the full axis.
  function automatic logic [CMP_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] r);
    logic [CMP_BITS-1:0] rw;
    rw = CMP_BITS'(r);
    return (rw < AXIS_SIZE) ? rw : AXIS_SIZE;
  endfunction

  function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [AXIS_BITS-1:0] x,
                                                     input logic [AXIS_BITS-1:0] y,
                                                     input logic [AXIS_BITS-1:0] z);
    return {z, y, x};
  endfunction

endpackage

// File: hw/rtl/voxel_face_visibility_grid_core.sv
`timescale 1ns / 1ps

// Channel   Ports                                   Direction  Handshake
// request   start, busy, req                        in         start && !busy
// config    cfg_valid, cfg_ready, cfg_index, cfg_data in       cfg_valid && cfg_ready
// result    done, result                            out        done, one cycle
//
// A query passes through one center access, six neighbor reads and one final
// compare, all on the single grid memory port.
// Busy drops with done, so the next request is taken at the edge that ends
// the done cycle; no new request is taken while one is in flight.
// A write takes the same path; an outside coordinate answers in the next cycle.
// After reset a clearing pass writes every one of the 32768 cells to empty,
// one per cycle, with busy high; config writes are taken throughout.
// The receiver cannot stall: each result is shown for exactly one cycle.

module voxel_face_visibility_grid_core
  import vfv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  req,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_BITS-1:0]  cfg_index,
  input  logic [SIZE_BITS-1:0] cfg_data,
  output logic                 done,
  output res_t                 result
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_ACCESS = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_LAST   = 3'd4;

  localparam logic [2:0] LAST_STEP = 3'(FACE_COUNT - 1);

  logic [2:0]            state;
  logic [ADDR_BITS-1:0]  clear_addr;
  logic [2:0]            step;
  in_t                   item;
  logic [TYPE_BITS-1:0]  center;
  logic [FACE_COUNT-2:0] mask;
  logic                  pend_open;

  logic [SIZE_BITS-1:0]  grid_wide;
  logic [SIZE_BITS-1:0]  grid_high;
  logic [SIZE_BITS-1:0]  grid_deep;

  // Grid memory, single port, registered read.
  logic [TYPE_BITS-1:0]  grid_mem [CELL_COUNT];
  logic [ADDR_BITS-1:0]  mem_addr;
  logic                  mem_we;
  logic [TYPE_BITS-1:0]  mem_wdata;
  logic [TYPE_BITS-1:0]  rd_data;

  logic                  req_inside;
  logic [AXIS_BITS-1:0]  axis_val;
  logic [CMP_BITS-1:0]   axis_lim;
  logic [AXIS_BITS:0]    nb_coord;
  logic                  nb_inside;
  logic [AXIS_BITS-1:0]  nb_x;
  logic [AXIS_BITS-1:0]  nb_y;
  logic [AXIS_BITS-1:0]  nb_z;
  logic                  rd_open;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Config registers; unknown indexes drop the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_wide <= SIZE_RESET;
      grid_high <= SIZE_RESET;
      grid_deep <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_WIDE: grid_wide <= cfg_data;
        REG_GRID_HIGH: grid_high <= cfg_data;
        REG_GRID_DEEP: grid_deep <= cfg_data;
        default: ;
      endcase
    end
  end

  assign req_inside = (CMP_BITS'(req.pos_x) < clamp_size(grid_wide)) &&
                      (CMP_BITS'(req.pos_y) < clamp_size(grid_high)) &&
                      (CMP_BITS'(req.pos_z) < clamp_size(grid_deep));

  // Shared neighbor unit: step picks the axis (step/2) and the side (step odd is +1).
  // A step below zero wraps to all ones, which always lies past the clamped size.
  always_comb begin
    case (step[2:1])
      2'd0: begin
        axis_val = item.pos_x;
        axis_lim = clamp_size(grid_wide);
      end
      2'd1: begin
        axis_val = item.pos_y;
        axis_lim = clamp_size(grid_high);
      end
      default: begin
        axis_val = item.pos_z;
        axis_lim = clamp_size(grid_deep);
      end
    endcase
    nb_coord  = {1'b0, axis_val} + (step[0] ? (AXIS_BITS + 1)'(1) : {(AXIS_BITS + 1){1'b1}});
    nb_inside = (CMP_BITS'(nb_coord) < axis_lim);
    nb_x = item.pos_x;
    nb_y = item.pos_y;
    nb_z = item.pos_z;
    case (step[2:1])
      2'd0:    nb_x = nb_coord[AXIS_BITS-1:0];
      2'd1:    nb_y = nb_coord[AXIS_BITS-1:0];
      default: nb_z = nb_coord[AXIS_BITS-1:0];
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = item.new_type;
    case (state)
      ST_CLEAR: begin
        mem_addr  = clear_addr;
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      ST_ACCESS: begin
        mem_addr = cell_addr(item.pos_x, item.pos_y, item.pos_z);
        mem_we   = (item.func == FUNC_WRITE);
      end
      ST_SCAN: mem_addr = cell_addr(nb_x, nb_y, nb_z);
      default: mem_addr = cell_addr(item.pos_x, item.pos_y, item.pos_z);
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= mem_wdata;
    end
    rd_data <= grid_mem[mem_addr];
  end

  // Neighbor read back: open when it lay outside or holds an empty cell.
  assign rd_open = pend_open || (rd_data == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      step       <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          // Sweep the grid to empty before taking any request.
          clear_addr <= clear_addr + ADDR_BITS'(1);
          if (clear_addr == ADDR_BITS'(CELL_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            item <= req;
            if (req_inside) begin
              state <= ST_ACCESS;
            end else begin
              // Outside the grid: answer at once and change nothing.
              result <= '{cell_type: '0, face_mask: '0, out_of_range: 1'b1};
              done   <= 1'b1;
            end
          end
        end
        ST_ACCESS: begin
          step  <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          // Latch the center on the first read back; a write knows it already.
          if (step == '0) begin
            center <= (item.func == FUNC_WRITE) ? item.new_type : rd_data;
          end else begin
            mask[step - 3'd1] <= rd_open;
          end
          pend_open <= !nb_inside;
          if (step == LAST_STEP) begin
            state <= ST_LAST;
          end else begin
            step <= step + 3'd1;
          end
        end
        ST_LAST: begin
          result.cell_type    <= center;
          result.face_mask    <= (center == '0) ? '0 : {rd_open, mask};
          result.out_of_range <= 1'b0;
          done                <= 1'b1;
          state               <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Out-of-grid request answers in the very next cycle.
  a_oor_fast: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !req_inside |=> done && result.out_of_range)
    else $error("out-of-grid request did not answer at once");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.out_of_range |-> result.cell_type == '0 && result.face_mask == '0)
    else $error("out-of-grid result carries type or faces");

  a_empty_mask: assert property (@(posedge clk) disable iff (rst)
    done && result.cell_type == '0 |-> result.face_mask == '0)
    else $error("empty cell shows visible faces");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while the sequencer is still busy");

endmodule

// File: tb/sv/voxel_face_visibility_grid_checker.sv
`timescale 1ns / 1ps

module voxel_face_visibility_grid_checker
  import vfv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  in_t                  req,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [IDX_BITS-1:0]  cfg_index,
  input  logic [SIZE_BITS-1:0] cfg_data,
  input  logic                 done,
  input  res_t                 result,
  output int                   errors,
  output int                   pending
);

  logic [TYPE_BITS-1:0] shadow_grid [CELL_COUNT];
  logic [SIZE_BITS-1:0] size_x;
  logic [SIZE_BITS-1:0] size_y;
  logic [SIZE_BITS-1:0] size_z;
  res_t                 expected_faces [$];

  // Sizes beyond the memory behave as the full axis.
  function automatic int axis_limit(input logic [SIZE_BITS-1:0] r);
    int lim;
    lim = int'(r);
    return (lim > (1 << AXIS_BITS)) ? (1 << AXIS_BITS) : lim;
  endfunction

  function automatic bit in_grid(input int x, input int y, input int z);
    return x >= 0 && y >= 0 && z >= 0 && x < axis_limit(size_x) &&
           y < axis_limit(size_y) && z < axis_limit(size_z);
  endfunction

  function automatic int grid_slot(input int x, input int y, input int z);
    return (z << (2 * AXIS_BITS)) | (y << AXIS_BITS) | x;
  endfunction

  function automatic bit side_open(input int x, input int y, input int z);
    if (!in_grid(x, y, z)) return 1'b1;
    return shadow_grid[grid_slot(x, y, z)] == '0;
  endfunction

  // Apply one request to the shadow grid and return the answer it earns.
  function automatic res_t predict_visibility(input in_t r);
    res_t ans;
    int   x;
    int   y;
    int   z;
    int   slot;
    x   = int'(r.pos_x);
    y   = int'(r.pos_y);
    z   = int'(r.pos_z);
    ans = '0;
    if (!in_grid(x, y, z)) begin
      ans.out_of_range = 1'b1;
      return ans;
    end
    slot = grid_slot(x, y, z);
    if (r.func == FUNC_WRITE) shadow_grid[slot] = r.new_type;
    ans.cell_type = shadow_grid[slot];
    if (ans.cell_type != '0) begin
      ans.face_mask[0] = side_open(x - 1, y, z);
      ans.face_mask[1] = side_open(x + 1, y, z);
      ans.face_mask[2] = side_open(x, y - 1, z);
      ans.face_mask[3] = side_open(x, y + 1, z);
      ans.face_mask[4] = side_open(x, y, z - 1);
      ans.face_mask[5] = side_open(x, y, z + 1);
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      for (int i = 0; i < CELL_COUNT; i++) shadow_grid[i] = '0;
      size_x = SIZE_RESET;
      size_y = SIZE_RESET;
      size_z = SIZE_RESET;
      expected_faces.delete();
      errors  = 0;
      pending <= 0;
    end else begin
      if (done) begin
        if (expected_faces.size() == 0) begin
          $error("result with no request outstanding: cell_type %0d face_mask %b oor %b",
                 result.cell_type, result.face_mask, result.out_of_range);
          errors++;
        end else begin
          want = expected_faces.pop_front();
          if (result.cell_type !== want.cell_type) begin
            $error("cell_type: expected %0d, got %0d", want.cell_type, result.cell_type);
            errors++;
          end
          if (result.face_mask !== want.face_mask) begin
            $error("face_mask: expected %b, got %b", want.face_mask, result.face_mask);
            errors++;
          end
          if (result.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %b, got %b", want.out_of_range,
                   result.out_of_range);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRID_WIDE: size_x = cfg_data;
          REG_GRID_HIGH: size_y = cfg_data;
          REG_GRID_DEEP: size_z = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_faces.insert(expected_faces.size(), predict_visibility(req));
      end
      pending <= expected_faces.size();
    end
  end

endmodule

// File: tb/sv/voxel_face_visibility_grid_core_test.sv
`timescale 1ns / 1ps

module voxel_face_visibility_grid_core_test;
  import vfv_pkg::*;

  // The block decodes only three registers; this index must be dropped.
  localparam logic [IDX_BITS-1:0] REG_SPARE = 2'd3;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 55;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  in_t                  req;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IDX_BITS-1:0]  cfg_index;
  logic [SIZE_BITS-1:0] cfg_data;
  logic                 done;
  res_t                 result;
  int                   errors;
  int                   pending;
  bit                   steady;   // when set, offer requests back to back

  voxel_face_visibility_grid_core uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  voxel_face_visibility_grid_checker check (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result),
    .errors    (errors),
    .pending   (pending)
  );

  always #2 clk = ~clk;

  // Offer one request after a random idle gap and hold it until the block
  // takes it. Start is left high on acceptance so the next request can
  // follow without a bubble.
  task automatic issue(input logic f, input int x, input int y, input int z,
                       input int t);
    in_t item;
    int  gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.func     = f;
    item.pos_x    = AXIS_BITS'(x);
    item.pos_y    = AXIS_BITS'(y);
    item.pos_z    = AXIS_BITS'(z);
    item.new_type = TYPE_BITS'(t);
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every outstanding request has answered.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write the spare index with junk, then the three size registers. Valid
  // stays high across the burst and drops once at the end.
  task automatic set_grid(input int w, input int h, input int d);
    logic [IDX_BITS-1:0]  order [4];
    logic [SIZE_BITS-1:0] vals  [4];
    order[0] = REG_SPARE;     vals[0] = SIZE_BITS'($urandom);
    order[1] = REG_GRID_WIDE; vals[1] = SIZE_BITS'(w);
    order[2] = REG_GRID_HIGH; vals[2] = SIZE_BITS'(h);
    order[3] = REG_GRID_DEEP; vals[3] = SIZE_BITS'(d);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Place a small box of coordinates either anywhere or straddling the far
  // border, so neighbors and outside cells both come up often.
  function automatic int box_origin(input int lim, input int span);
    int far;
    if ($urandom_range(0, 1) == 1) return $urandom_range(0, 31);
    far = ((lim > 32) ? 32 : lim) - span + 1;
    return (far < 0) ? 0 : far;
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(1, 8);
    if (r < 8) return $urandom_range(9, 32);
    return $urandom_range(33, 63);
  endfunction

  // One setting of the grid, then a burst of writes and queries packed into
  // a small box, with a share of fully random noise requests.
  task automatic random_phase(input int w, input int h, input int d);
    int   bx;
    int   by;
    int   bz;
    int   span;
    int   x;
    int   y;
    int   z;
    int   t;
    logic f;
    drain();
    set_grid(w, h, d);
    steady = ($urandom_range(0, 2) == 0);
    span   = $urandom_range(2, 6);
    bx     = box_origin(w, span);
    by     = box_origin(h, span);
    bz     = box_origin(d, span);
    repeat (PHASE_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        f = ($urandom_range(0, 1) == 1) ? FUNC_QUERY : FUNC_WRITE;
        x = $urandom_range(0, 31);
        y = $urandom_range(0, 31);
        z = $urandom_range(0, 31);
        t = $urandom_range(0, 15);
      end else begin
        f = ($urandom_range(0, 99) < 45) ? FUNC_WRITE : FUNC_QUERY;
        x = (bx + $urandom_range(0, span - 1)) % 32;
        y = (by + $urandom_range(0, span - 1)) % 32;
        z = (bz + $urandom_range(0, span - 1)) % 32;
        t = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      end
      issue(f, x, y, z, t);
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_GRID_WIDE;
    cfg_data  = '0;
    steady    = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes: the whole 32-cube. The clearing pass holds busy, so the
    // first request simply waits for it.
    issue(FUNC_QUERY, 0, 0, 0, 0);        // empty cell answers a zero mask
    issue(FUNC_WRITE, 0, 0, 0, 15);       // lone block at the low corner
    issue(FUNC_WRITE, 1, 0, 0, 10);       // neighbor hides a shared face
    issue(FUNC_QUERY, 0, 0, 0, 0);
    issue(FUNC_WRITE, 31, 31, 31, 1);     // high corner
    issue(FUNC_WRITE, 31, 31, 30, 2);
    issue(FUNC_QUERY, 31, 31, 31, 0);
    issue(FUNC_WRITE, 1, 0, 0, 0);        // remove a block
    issue(FUNC_QUERY, 0, 0, 0, 0);
    issue(FUNC_QUERY, 31, 0, 31, 0);      // never written, cleared at reset

    // Small grid: border faces and coordinates outside.
    drain();
    set_grid(4, 4, 4);
    issue(FUNC_WRITE, 3, 3, 3, 7);
    issue(FUNC_WRITE, 2, 3, 3, 3);
    issue(FUNC_QUERY, 4, 0, 0, 0);
    issue(FUNC_WRITE, 31, 31, 31, 9);     // outside: must not change the cell

    // Sizes above the memory act as full axes; a one-deep world in z.
    drain();
    set_grid(63, 33, 1);
    issue(FUNC_QUERY, 31, 0, 0, 0);
    issue(FUNC_WRITE, 31, 31, 0, 4);
    issue(FUNC_QUERY, 0, 0, 0, 0);

    // Zero width: everything is outside, writes included.
    drain();
    set_grid(0, 32, 32);
    issue(FUNC_QUERY, 0, 0, 0, 0);
    issue(FUNC_WRITE, 0, 0, 0, 6);

    // Shrink past a stored block, then grow back and find it kept.
    drain();
    set_grid(3, 4, 4);
    issue(FUNC_QUERY, 2, 3, 3, 0);
    issue(FUNC_QUERY, 3, 3, 3, 0);
    drain();
    set_grid(4, 4, 4);
    issue(FUNC_QUERY, 3, 3, 3, 0);
    issue(FUNC_QUERY, 2, 3, 3, 0);
    issue(FUNC_QUERY, 0, 0, 0, 0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       random_phase(32, 32, 32);
        1:       random_phase(63, 40, 33);
        2:       random_phase(1, 1, 1);
        3:       random_phase(0, 4, 4);
        default: random_phase(pick_size(), pick_size(), pick_size());
      endcase
    end

    // Let every answer land, then watch a little longer for strays.
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("** voxel_face_visibility_grid_core: PASSED **");
    end else begin
      $display("** voxel_face_visibility_grid_core: FAILED **");
    end
    $finish;
  end

  // Bound the run: the clearing pass plus every request at full latency and
  // widest gap fits many times over.
  initial begin
    #2000000;
    $display("** voxel_face_visibility_grid_core: FAILED **");
    $finish;
  end

endmodule
